@@ design/vrp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and constants for the vertex rotate and project pipeline.
// No dependencies; every other design file imports this package.
package vrp_pkg;

    localparam int V_W        = 16;
    localparam int ANG_W      = 16;
    localparam int P1_W       = 32;
    localparam int X1_W       = 33;
    localparam int Z1_W       = 30;
    localparam int P3_W       = 49;
    localparam int Y2_W       = 47;
    localparam int ROT_W      = 50;
    localparam int ROT_SHIFT  = 14;
    localparam int OFF_SHIFT  = 26;
    localparam int DEPTH_OFFSET = 10;
    localparam int DEPTH_SHIFT  = 40;
    localparam int QUO_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [ROT_W-1:0] DEPTH_BIAS = ROT_W'(DEPTH_OFFSET) << DEPTH_SHIFT;

    localparam logic signed [V_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [V_W-1:0] SAT_MIN = 16'sh8000;
    localparam logic [QUO_W-1:0] SAT_POS_MAG = 17'd32767;
    localparam logic [QUO_W-1:0] SAT_NEG_MAG = 17'd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_COS_ANGLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_ANGLE = 2'd1;

    localparam logic signed [ANG_W-1:0] COS_RESET = 16'sd16384;
    localparam logic signed [ANG_W-1:0] SIN_RESET = 16'sd0;

    typedef struct packed {
        logic signed [V_W-1:0] vertex_x;
        logic signed [V_W-1:0] vertex_y;
        logic signed [V_W-1:0] vertex_z;
    } t_vertex_in;

    typedef struct packed {
        logic signed [V_W-1:0] screen_x;
        logic signed [V_W-1:0] screen_y;
        logic                  behind_camera;
    } t_screen_out;

    typedef struct packed {
        logic signed [ROT_W-1:0] xo;
        logic signed [ROT_W-1:0] yo;
        logic signed [ROT_W-1:0] zo;
    } t_rot;

    function automatic int f_num_width(input int w, input int h);
        int m;
        m = (w > h) ? w : h;
        return ROT_W + $clog2(m + 1) + 2;
    endfunction

endpackage

@@ design/vrp_rotate.sv @@
`timescale 1ns / 1ps
// Four-stage rotation about Z then Y, followed by the cosine, sine and depth offsets.
// Depends on vrp_pkg.
module vrp_rotate (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  vrp_pkg::t_vertex_in          i_vertex,
    input  logic signed [vrp_pkg::ANG_W-1:0] i_cos,
    input  logic signed [vrp_pkg::ANG_W-1:0] i_sin,
    output logic                         o_valid,
    output vrp_pkg::t_rot                o_rot
);
    import vrp_pkg::*;

    logic [3:0] r_v;

    logic signed [P1_W-1:0] r_xc, r_ys, r_xs, r_yc;
    logic signed [Z1_W-1:0] r_z1a;
    logic signed [X1_W-1:0] r_x1, r_y1;
    logic signed [Z1_W-1:0] r_z1b;
    logic signed [P3_W-1:0] r_x1c, r_z1s, r_x1s, r_z1c;
    logic signed [Y2_W-1:0] r_y2;
    t_rot                   r_rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xc  <= P1_W'(i_vertex.vertex_x) * P1_W'(i_cos);
            r_ys  <= P1_W'(i_vertex.vertex_y) * P1_W'(i_sin);
            r_xs  <= P1_W'(i_vertex.vertex_x) * P1_W'(i_sin);
            r_yc  <= P1_W'(i_vertex.vertex_y) * P1_W'(i_cos);
            r_z1a <= Z1_W'(i_vertex.vertex_z) <<< ROT_SHIFT;

            r_x1  <= X1_W'(r_xc) - X1_W'(r_ys);
            r_y1  <= X1_W'(r_xs) + X1_W'(r_yc);
            r_z1b <= r_z1a;

            r_x1c <= P3_W'(r_x1) * P3_W'(i_cos);
            r_z1s <= P3_W'(r_z1b) * P3_W'(i_sin);
            r_x1s <= P3_W'(r_x1) * P3_W'(i_sin);
            r_z1c <= P3_W'(r_z1b) * P3_W'(i_cos);
            r_y2  <= Y2_W'(r_y1) <<< ROT_SHIFT;

            r_rot.xo <= ROT_W'(r_x1c) - ROT_W'(r_z1s) + (ROT_W'(i_cos) <<< OFF_SHIFT);
            r_rot.yo <= ROT_W'(r_y2) + (ROT_W'(i_sin) <<< OFF_SHIFT);
            r_rot.zo <= ROT_W'(r_x1s) + ROT_W'(r_z1c) + DEPTH_BIAS;
        end
    end

    assign o_valid = r_v[3];
    assign o_rot   = r_rot;

endmodule

@@ design/vrp_scale.sv @@
`timescale 1ns / 1ps
// Three-stage screen scaling: builds both projection numerators, then splits them
// into sign and magnitude and flags a depth that is not positive. Depends on vrp_pkg.
module vrp_scale #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 600
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  vrp_pkg::t_rot       i_rot,
    output logic                o_valid,
    output logic [vrp_pkg::f_num_width(SCREEN_WIDTH, SCREEN_HEIGHT)-1:0] o_mag_x,
    output logic [vrp_pkg::f_num_width(SCREEN_WIDTH, SCREEN_HEIGHT)-1:0] o_mag_y,
    output logic                o_neg_x,
    output logic                o_neg_y,
    output logic [vrp_pkg::ROT_W-2:0] o_den,
    output logic                o_behind
);
    import vrp_pkg::*;

    localparam int NUM_W = f_num_width(SCREEN_WIDTH, SCREEN_HEIGHT);
    localparam logic signed [NUM_W-1:0] K_W_FULL = NUM_W'(SCREEN_WIDTH);
    localparam logic signed [NUM_W-1:0] K_W_HALF = NUM_W'(SCREEN_WIDTH / 2);
    localparam logic signed [NUM_W-1:0] K_H_HALF = NUM_W'(SCREEN_HEIGHT / 2);

    logic [2:0] r_v;

    logic signed [NUM_W-1:0] r_pxw, r_pyw, r_pzw, r_pzh;
    logic signed [ROT_W-1:0] r_zo5, r_zo6;
    logic signed [NUM_W-1:0] r_nx, r_ny;
    logic [NUM_W-1:0]        r_mag_x, r_mag_y;
    logic                    r_neg_x, r_neg_y, r_behind;
    logic [ROT_W-2:0]        r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxw <= NUM_W'(i_rot.xo) * K_W_FULL;
            r_pyw <= NUM_W'(i_rot.yo) * K_W_FULL;
            r_pzw <= NUM_W'(i_rot.zo) * K_W_HALF;
            r_pzh <= NUM_W'(i_rot.zo) * K_H_HALF;
            r_zo5 <= i_rot.zo;

            r_nx  <= r_pxw + r_pzw;
            r_ny  <= r_pzh - r_pyw;
            r_zo6 <= r_zo5;

            r_neg_x  <= r_nx[NUM_W-1];
            r_neg_y  <= r_ny[NUM_W-1];
            r_mag_x  <= r_nx[NUM_W-1] ? $unsigned(-r_nx) : $unsigned(r_nx);
            r_mag_y  <= r_ny[NUM_W-1] ? $unsigned(-r_ny) : $unsigned(r_ny);
            r_den    <= r_zo6[ROT_W-2:0];
            r_behind <= r_zo6[ROT_W-1] || (r_zo6 == '0);
        end
    end

    assign o_valid  = r_v[2];
    assign o_mag_x  = r_mag_x;
    assign o_mag_y  = r_mag_y;
    assign o_neg_x  = r_neg_x;
    assign o_neg_y  = r_neg_y;
    assign o_den    = r_den;
    assign o_behind = r_behind;

endmodule

@@ design/vrp_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider: one overflow check stage, then one quotient bit per stage.
// Depends on vrp_pkg for the quotient width.
module vrp_div #(
    parameter int NUM_W = 66,
    parameter int DEN_W = 49
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [NUM_W-1:0]          i_num,
    input  logic [DEN_W-1:0]          i_den,
    input  logic                      i_neg,
    output logic                      o_valid,
    output logic [vrp_pkg::QUO_W-1:0] o_quo,
    output logic                      o_ovf,
    output logic                      o_neg
);
    import vrp_pkg::*;

    localparam int CMP_W = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

    logic             r_v   [0:QUO_W];
    logic [QUO_W-1:0] r_q   [0:QUO_W];
    logic             r_neg [0:QUO_W];
    logic             r_ovf [0:QUO_W];
    logic [NUM_W-1:0] r_rem [0:QUO_W-1];
    logic [DEN_W-1:0] r_den [0:QUO_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_neg[0] <= i_neg;
            r_ovf[0] <= CMP_W'(i_num) >= (CMP_W'(i_den) << QUO_W);
        end
    end

    for (genvar i = 1; i <= QUO_W; i++) begin : g_step
        localparam int SH = QUO_W - i;
        logic [CMP_W-1:0] w_trial;
        logic             w_fit;

        always_comb begin
            w_trial = CMP_W'(r_den[i-1]) << SH;
            w_fit   = CMP_W'(r_rem[i-1]) >= w_trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (i_en) begin
                r_v[i] <= r_v[i-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[i]   <= {r_q[i-1][QUO_W-2:0], w_fit};
                r_neg[i] <= r_neg[i-1];
                r_ovf[i] <= r_ovf[i-1];
            end
        end

        if (i < QUO_W) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[i] <= w_fit ? NUM_W'(CMP_W'(r_rem[i-1]) - w_trial) : r_rem[i-1];
                    r_den[i] <= r_den[i-1];
                end
            end
        end
    end

    assign o_valid = r_v[QUO_W];
    assign o_quo   = r_q[QUO_W];
    assign o_ovf   = r_ovf[QUO_W];
    assign o_neg   = r_neg[QUO_W];

endmodule

@@ design/vertex_rotate_project.sv @@
`timescale 1ns / 1ps
// Top level of the vertex rotate and project pipeline with its configuration registers.
// Depends on vrp_pkg, vrp_rotate, vrp_scale and vrp_div.
//
// Usage:
// A vertex transaction (i_vertex) is taken at a rising edge with i_valid high and
// o_stall low. Its screen result (o_screen) is delivered at an edge with o_valid
// high and i_stall low. Results leave in the order the vertices came in.
// The pipeline takes one vertex per cycle while o_stall is low. From the accepting
// edge to o_valid a vertex passes four rotation stages, three scaling stages,
// eighteen divider stages (one overflow check plus one quotient bit each),
// one saturation stage and the output register.
// When the receiver stalls, the output register holds its transaction and a skid
// register catches the next one; the whole pipeline then freezes and o_stall rises
// until the output drains. Nothing is lost or repeated.
// The angle registers are written through i_cfg_we, i_cfg_index and i_cfg_data;
// the user must do so only while no vertex is in flight; the block does not check.
// A synchronous low i_rst_n empties the pipeline and loads cosine 16384 and sine 0.
module vertex_rotate_project #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 600
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  vrp_pkg::t_vertex_in               i_vertex,
    output logic                              o_valid,
    input  logic                              i_stall,
    output vrp_pkg::t_screen_out              o_screen,
    input  logic                              i_cfg_we,
    input  logic [vrp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vrp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import vrp_pkg::*;

    localparam int NUM_W     = f_num_width(SCREEN_WIDTH, SCREEN_HEIGHT);
    localparam int DEN_W     = ROT_W - 1;
    localparam int DIV_DEPTH = QUO_W + 1;

    logic signed [ANG_W-1:0] r_cos, r_sin;

    logic             w_en;
    logic             w_rot_valid;
    t_rot             w_rot;
    logic             w_sc_valid;
    logic [NUM_W-1:0] w_mag_x, w_mag_y;
    logic             w_neg_x, w_neg_y;
    logic [DEN_W-1:0] w_den;
    logic             w_behind;

    logic             w_dx_valid, w_dy_valid;
    logic [QUO_W-1:0] w_qx, w_qy;
    logic             w_ox, w_oy, w_nx, w_ny;

    logic             r_bh [0:DIV_DEPTH-1];

    t_screen_out      n_res;
    t_screen_out      r_res, r_out, r_skid;
    logic             r_res_v, r_out_v, r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos <= COS_RESET;
            r_sin <= SIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COS_ANGLE: r_cos <= $signed(i_cfg_data);
                CFG_SIN_ANGLE: r_sin <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    assign w_en    = !r_skid_v;
    assign o_stall = r_skid_v;

    vrp_rotate u_rotate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_vertex (i_vertex),
        .i_cos    (r_cos),
        .i_sin    (r_sin),
        .o_valid  (w_rot_valid),
        .o_rot    (w_rot)
    );

    vrp_scale #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_rot_valid),
        .i_rot    (w_rot),
        .o_valid  (w_sc_valid),
        .o_mag_x  (w_mag_x),
        .o_mag_y  (w_mag_y),
        .o_neg_x  (w_neg_x),
        .o_neg_y  (w_neg_y),
        .o_den    (w_den),
        .o_behind (w_behind)
    );

    vrp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sc_valid),
        .i_num   (w_mag_x),
        .i_den   (w_den),
        .i_neg   (w_neg_x),
        .o_valid (w_dx_valid),
        .o_quo   (w_qx),
        .o_ovf   (w_ox),
        .o_neg   (w_nx)
    );

    vrp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sc_valid),
        .i_num   (w_mag_y),
        .i_den   (w_den),
        .i_neg   (w_neg_y),
        .o_valid (w_dy_valid),
        .o_quo   (w_qy),
        .o_ovf   (w_oy),
        .o_neg   (w_ny)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bh[0] <= w_behind;
            for (int i = 1; i < DIV_DEPTH; i++) begin
                r_bh[i] <= r_bh[i-1];
            end
        end
    end

    function automatic logic signed [V_W-1:0] f_sat(
        input logic             neg,
        input logic             ovf,
        input logic [QUO_W-1:0] q
    );
        logic [QUO_W-1:0] lim;
        logic [V_W-1:0]   mag;
        lim = neg ? SAT_NEG_MAG : SAT_POS_MAG;
        mag = q[V_W-1:0];
        if (ovf || (q > lim)) begin
            return neg ? SAT_MIN : SAT_MAX;
        end
        return neg ? $signed(-mag) : $signed(mag);
    endfunction

    always_comb begin
        if (r_bh[DIV_DEPTH-1]) begin
            n_res.screen_x      = '0;
            n_res.screen_y      = '0;
            n_res.behind_camera = 1'b1;
        end else begin
            n_res.screen_x      = f_sat(w_nx, w_ox, w_qx);
            n_res.screen_y      = f_sat(w_ny, w_oy, w_qy);
            n_res.behind_camera = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_v <= 1'b0;
        end else if (w_en) begin
            r_res_v <= w_dx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_stall) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= r_res_v;
            end
        end else if (r_res_v && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_stall) begin
            r_out <= r_skid_v ? r_skid : r_res;
        end else if (!r_skid_v) begin
            r_skid <= r_res;
        end
    end

    assign o_valid  = r_out_v;
    assign o_screen = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("Skid register holds a transaction while the output is empty.");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && i_stall))
        else $error("Skid register filled without a stalled output.");

    a_behind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_screen.behind_camera) |->
            (o_screen.screen_x == '0 && o_screen.screen_y == '0))
        else $error("Vertex behind the camera carries nonzero coordinates.");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dx_valid == w_dy_valid)
        else $error("Column and row dividers are out of step.");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for vertex_rotate_project: random and directed vertices under
// several angle settings, checked against an exact 64-bit projection computed here.
// Depends on vrp_pkg and the vertex_rotate_project design files.
module tb_top;
    import vrp_pkg::*;

    localparam int SCREEN_W = 800;
    localparam int SCREEN_H = 600;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_VERTICES = 175;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_vertex_in            i_vertex = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_screen_out           o_screen;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic signed [ANG_W-1:0] cos_val = COS_RESET;
    logic signed [ANG_W-1:0] sin_val = SIN_RESET;

    t_vertex_in  vertex_q[$];
    t_screen_out screen_q[$];

    bit no_idle = 1'b0;
    bit rx_hold_req = 1'b0;
    bit rx_hold_seen = 1'b0;
    int hold_left = 0;
    int err_cnt = 0;
    int sent_cnt = 0;
    int setting_cnt = 1;
    int behind_cnt = 0;
    int clamp_cnt = 0;

    vertex_rotate_project #(
        .SCREEN_WIDTH (SCREEN_W),
        .SCREEN_HEIGHT(SCREEN_H)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_vertex   (i_vertex),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_screen   (o_screen),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_screen_out project_vertex(input t_vertex_in v,
                                                   input logic signed [ANG_W-1:0] ca,
                                                   input logic signed [ANG_W-1:0] sa);
        longint c, s, x, y, z;
        longint x1, y1, z1, x2, y2, z2;
        longint xo, yo, zo, nx, ny, qx, qy;
        t_screen_out r;
        c = longint'(ca);
        s = longint'(sa);
        x = longint'(v.vertex_x);
        y = longint'(v.vertex_y);
        z = longint'(v.vertex_z);
        x1 = x * c - y * s;
        y1 = x * s + y * c;
        z1 = z * (longint'(1) << ROT_SHIFT);
        x2 = x1 * c - z1 * s;
        y2 = y1 * (longint'(1) << ROT_SHIFT);
        z2 = x1 * s + z1 * c;
        xo = x2 + c * (longint'(1) << OFF_SHIFT);
        yo = y2 + s * (longint'(1) << OFF_SHIFT);
        zo = z2 + (longint'(DEPTH_OFFSET) << DEPTH_SHIFT);
        r = '0;
        if (zo <= 0) begin
            r.behind_camera = 1'b1;
        end else begin
            nx = xo * longint'(SCREEN_W) + longint'(SCREEN_W / 2) * zo;
            ny = -yo * longint'(SCREEN_W) + longint'(SCREEN_H / 2) * zo;
            qx = nx / zo;
            qy = ny / zo;
            r.screen_x = (qx > 32767) ? SAT_MAX : (qx < -32768) ? SAT_MIN : 16'(qx);
            r.screen_y = (qy > 32767) ? SAT_MAX : (qy < -32768) ? SAT_MIN : 16'(qy);
        end
        return r;
    endfunction

    function automatic logic [V_W-1:0] pick_coord();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return 16'($urandom);
        if (r < 9) return 16'($urandom_range(0, 16383) - 8192);
        return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
    endfunction

    task automatic queue_vertex(input int x, input int y, input int z);
        t_vertex_in v;
        v.vertex_x = 16'(x);
        v.vertex_y = 16'(y);
        v.vertex_z = 16'(z);
        vertex_q.push_back(v);
    endtask

    task automatic write_angle_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_COS_ANGLE: cos_val = data;
            CFG_SIN_ANGLE: sin_val = data;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (vertex_q.size() != 0 || i_valid || screen_q.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                screen_q.push_back(project_vertex(i_vertex, cos_val, sin_val));
                sent_cnt++;
            end
            if (!i_valid || !o_stall) begin
                if (vertex_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= 36)) begin
                    i_vertex <= vertex_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_screen_out exp_scr;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_hold_seen <= 1'b0;
            hold_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (screen_q.size() == 0) begin
                    $error("result transaction with no vertex outstanding");
                    err_cnt++;
                end else begin
                    exp_scr = screen_q.pop_front();
                    if (o_screen.screen_x !== exp_scr.screen_x) begin
                        $error("screen_x mismatch: expected %0d, actual %0d",
                               exp_scr.screen_x, o_screen.screen_x);
                        err_cnt++;
                    end
                    if (o_screen.screen_y !== exp_scr.screen_y) begin
                        $error("screen_y mismatch: expected %0d, actual %0d",
                               exp_scr.screen_y, o_screen.screen_y);
                        err_cnt++;
                    end
                    if (o_screen.behind_camera !== exp_scr.behind_camera) begin
                        $error("behind_camera mismatch: expected %0b, actual %0b",
                               exp_scr.behind_camera, o_screen.behind_camera);
                        err_cnt++;
                    end
                    if (exp_scr.behind_camera) begin
                        behind_cnt++;
                    end else if (exp_scr.screen_x == SAT_MAX || exp_scr.screen_x == SAT_MIN ||
                                 exp_scr.screen_y == SAT_MAX || exp_scr.screen_y == SAT_MIN) begin
                        clamp_cnt++;
                    end
                end
            end
            rx_hold_seen <= rx_hold_req;
            if (rx_hold_req && !rx_hold_seen) begin
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !no_idle && ($urandom_range(0, 99) < 36);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        queue_vertex(0, 0, 0);
        queue_vertex(32767, 32767, 32767);
        queue_vertex(-32768, -32768, -32768);
        queue_vertex(32767, -32768, 0);
        queue_vertex(-32768, 32767, -1);
        queue_vertex(1, -1, 32767);
        wait_drained();

        // Zero cosine with the most negative sine puts depth exactly at zero for y = 10240.
        write_angle_reg(CFG_COS_ANGLE, 16'h0000);
        write_angle_reg(CFG_SIN_ANGLE, 16'h8000);
        setting_cnt++;
        @(negedge i_clk);
        queue_vertex(0, 10240, 0);
        queue_vertex(0, 10241, 5);
        queue_vertex(0, 10239, 0);
        queue_vertex(-32768, 10239, 32767);
        queue_vertex(32767, 10239, -32768);
        queue_vertex(100, -32768, 100);
        wait_drained();

        write_angle_reg(CFG_COS_ANGLE, 16'h8000);
        write_angle_reg(CFG_SIN_ANGLE, 16'h8000);
        write_angle_reg(CFG_SPARE_2, 16'h1234);
        write_angle_reg(CFG_SPARE_3, 16'hFFFF);
        setting_cnt++;
        @(negedge i_clk);
        queue_vertex(-32768, 32767, 32767);
        queue_vertex(32767, -32768, -32768);
        queue_vertex(0, 0, 0);
        queue_vertex(1, 1, 1);
        wait_drained();

        write_angle_reg(CFG_COS_ANGLE, 16'h7FFF);
        write_angle_reg(CFG_SIN_ANGLE, 16'h7FFF);
        setting_cnt++;
        @(negedge i_clk);
        queue_vertex(32767, 32767, 32767);
        queue_vertex(-32768, -32768, -32768);
        queue_vertex(-32768, 32767, 0);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: begin
                    write_angle_reg(CFG_COS_ANGLE, 16'd16384);
                    write_angle_reg(CFG_SIN_ANGLE, 16'd0);
                end
                1: begin
                    write_angle_reg(CFG_COS_ANGLE, -16'sd16384);
                    write_angle_reg(CFG_SIN_ANGLE, 16'd0);
                end
                2: begin
                    write_angle_reg(CFG_COS_ANGLE, 16'd0);
                    write_angle_reg(CFG_SIN_ANGLE, 16'd16384);
                end
                3: begin
                    write_angle_reg(CFG_COS_ANGLE, 16'd11585);
                    write_angle_reg(CFG_SIN_ANGLE, -16'sd11585);
                end
                4: begin
                    write_angle_reg(CFG_COS_ANGLE, -16'sd16384);
                    write_angle_reg(CFG_SIN_ANGLE, -16'sd16384);
                end
                default: begin
                    write_angle_reg(CFG_COS_ANGLE, 16'($urandom));
                    write_angle_reg(CFG_SIN_ANGLE, 16'($urandom));
                end
            endcase
            setting_cnt++;
            @(negedge i_clk);
            no_idle = (p == 0);
            rx_hold_req = (p == 3);
            for (int k = 0; k < PHASE_VERTICES; k++) begin
                queue_vertex(int'(pick_coord()), int'(pick_coord()), int'(pick_coord()));
            end
            wait_drained();
        end
        no_idle = 1'b0;
        rx_hold_req = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (screen_q.size() != 0) begin
            $error("%0d screen results never arrived", screen_q.size());
            err_cnt++;
        end
        $display("Projected %0d vertices under %0d angle settings.", sent_cnt, setting_cnt);
        $display("%0d landed behind the camera and %0d hit a screen coordinate limit.",
                 behind_cnt, clamp_cnt);
        if (err_cnt == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
